@@ design/estw_pkg.sv @@
// Shared types and constants for the edge span table walker.
package estw_pkg;

  // Widths of the grid coordinates, the depth and the reported row index.
  localparam int COL_W   = 8;
  localparam int DEPTH_W = 32;
  localparam int ROWI_W  = 3;
  // Walk coordinates carry one extra step past the grid on each side.
  localparam int WALK_W  = 10;
  // Accumulator holds at most major plus minor delta.
  localparam int ACC_W   = 9;
  // Most rows reported on a closing edge.
  localparam int EMIT_MAX = 8;
  // Serial divider steps, one quotient bit each.
  localparam int DIV_STEPS = 32;

  // Row occupancy codes.
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_POINT = 2'd1,
    KIND_SPAN  = 2'd2
  } kind_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_WALK_RD,
    ST_WALK_WR,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  // One input item: an edge between two grid points with depths.
  typedef struct packed {
    logic signed [COL_W-1:0]   src_u;
    logic signed [COL_W-1:0]   src_v;
    logic signed [DEPTH_W-1:0] src_w;
    logic signed [COL_W-1:0]   dst_u;
    logic signed [COL_W-1:0]   dst_v;
    logic signed [DEPTH_W-1:0] dst_w;
    logic                      closes_shape;
  } in_item_t;

  // One result item: one row of the span table.
  typedef struct packed {
    logic [ROWI_W-1:0]         row_index;
    kind_t                     span_kind;
    logic signed [COL_W-1:0]   left_u;
    logic signed [DEPTH_W-1:0] left_w;
    logic signed [COL_W-1:0]   right_u;
    logic signed [DEPTH_W-1:0] right_w;
    logic                      last_row;
  } out_item_t;

  // One span table entry as stored in memory.
  typedef struct packed {
    logic signed [COL_W-1:0]   left_u;
    logic signed [COL_W-1:0]   right_u;
    logic signed [DEPTH_W-1:0] left_w;
    logic signed [DEPTH_W-1:0] right_w;
  } row_entry_t;

endpackage

@@ design/estw_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module estw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/edge_span_table_walker.sv @@
// Edge span table walker: Bresenham edge walk into a per-row span table in RAM.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_ready  | in_item  (in_item_t, one edge)
//   out     | output    | out_valid/out_ready| out_item (out_item_t, one table row)
//
// An edge goes through setup, then serial division for the depth step (one
// quotient bit per cycle), then a walk of major delta plus one points: each
// point is a read-modify-write of the single table RAM (read, then write).
// A closing edge then reports min(ROWS, 8) rows and clears the row kinds as
// it reports the last one. No clearing pass runs after reset; row kinds sit in
// flip-flops that reset clears. A stalled output holds the reporting of the next
// row; the last row may wait in the output register while the next edge is taken.
module edge_span_table_walker
  import estw_pkg::*;
#(
  parameter int ROWS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int RW     = $clog2(ROWS);
  localparam int EMIT_N = (ROWS < EMIT_MAX) ? ROWS : EMIT_MAX;
  localparam logic [WALK_W-1:0] ROWS_C   = WALK_W'(ROWS);
  localparam logic [WALK_W-1:0] STEP_INC = WALK_W'(1);
  localparam logic [WALK_W-1:0] STEP_DEC = '1;
  localparam logic [ROWI_W-1:0] LAST_ROW = ROWI_W'(EMIT_N - 1);
  localparam logic [4:0]        DIV_LAST = 5'(DIV_STEPS - 1);

  // Control and walk registers.
  state_t                  state_r, state_nxt;
  in_item_t                in_r, in_nxt;
  kind_t [ROWS-1:0]        kind_r, kind_nxt;
  logic [COL_W-1:0]        maj_r, maj_nxt;
  logic [COL_W-1:0]        min_r, min_nxt;
  logic                    umaj_r, umaj_nxt;
  logic                    udec_r, udec_nxt;
  logic                    vdec_r, vdec_nxt;
  logic [COL_W:0]          cnt_r, cnt_nxt;
  logic [ACC_W-1:0]        acc_r, acc_nxt;
  logic [WALK_W-1:0]       u_r, u_nxt;
  logic [WALK_W-1:0]       v_r, v_nxt;
  logic [DEPTH_W-1:0]      w_r, w_nxt;
  logic                    inrow_r, inrow_nxt;
  logic                    neg_r, neg_nxt;
  logic [DEPTH_W-1:0]      dvd_r, dvd_nxt;
  logic [COL_W-1:0]        rem_r, rem_nxt;
  logic [4:0]              dcnt_r, dcnt_nxt;
  logic [DEPTH_W-1:0]      step_r, step_nxt;
  logic [ROWI_W-1:0]       erow_r, erow_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_item_r, out_item_nxt;

  // RAM port signals.
  logic                    ram_we;
  logic [RW-1:0]           ram_wr_addr;
  row_entry_t              ram_wr_data;
  logic                    ram_rd_en;
  logic [RW-1:0]           ram_rd_addr;
  row_entry_t              ram_rd_data;

  // Setup arithmetic.
  logic signed [COL_W:0]   du, dv;
  logic [COL_W:0]          du_neg, dv_neg;
  logic [COL_W-1:0]        adu, adv;
  logic [DEPTH_W:0]        wdiff, wdiff_neg;

  // Division step.
  logic [COL_W:0]          rem_sh;
  logic                    q_bit;
  logic [COL_W:0]          rem_sub;

  // Point selection and merge.
  logic                    minor_step;
  logic [ACC_W-1:0]        acc_pt;
  logic [WALK_W-1:0]       u_pt, v_pt;
  logic                    v_pt_in;
  logic signed [COL_W-1:0] u_sat;
  kind_t                   kind_cur;
  row_entry_t              merged;
  kind_t                   kind_emit;
  logic                    load_ok;

  estw_ram #(
    .WIDTH($bits(row_entry_t)),
    .DEPTH(ROWS)
  ) u_table (
    .clk    (clk),
    .we     (ram_we),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // Edge deltas with the zero-counts-as-one rule, and the depth difference.
  always_comb begin
    du        = $signed({in_r.dst_u[COL_W-1], in_r.dst_u})
              - $signed({in_r.src_u[COL_W-1], in_r.src_u});
    dv        = $signed({in_r.dst_v[COL_W-1], in_r.dst_v})
              - $signed({in_r.src_v[COL_W-1], in_r.src_v});
    du_neg    = -du;
    dv_neg    = -dv;
    adu       = (du == '0) ? COL_W'(1) : (du[COL_W] ? du_neg[COL_W-1:0] : du[COL_W-1:0]);
    adv       = (dv == '0) ? COL_W'(1) : (dv[COL_W] ? dv_neg[COL_W-1:0] : dv[COL_W-1:0]);
    wdiff     = {in_r.dst_w[DEPTH_W-1], in_r.dst_w} - {in_r.src_w[DEPTH_W-1], in_r.src_w};
    wdiff_neg = -wdiff;
  end

  // One restoring division step on the magnitude of the depth difference.
  always_comb begin
    rem_sh  = {rem_r, dvd_r[DEPTH_W-1]};
    q_bit   = (rem_sh >= {1'b0, maj_r});
    rem_sub = rem_sh - {1'b0, maj_r};
  end

  // Current walk point: minor axis steps once the accumulator reaches the major delta.
  always_comb begin
    minor_step = (acc_r >= ACC_W'(maj_r));
    acc_pt     = minor_step ? (acc_r - ACC_W'(maj_r)) : acc_r;
    u_pt       = u_r;
    v_pt       = v_r;
    if (minor_step && !umaj_r) begin
      u_pt = u_r + (udec_r ? STEP_DEC : STEP_INC);
    end
    if (minor_step && umaj_r) begin
      v_pt = v_r + (vdec_r ? STEP_DEC : STEP_INC);
    end
    v_pt_in = !v_pt[WALK_W-1] && (v_pt < ROWS_C);
  end

  // Merge the registered point into the row entry read from the table.
  always_comb begin
    if ($signed(u_r) < -$signed(WALK_W'(128))) begin
      u_sat = -8'sd128;
    end else if ($signed(u_r) > $signed(WALK_W'(127))) begin
      u_sat = 8'sd127;
    end else begin
      u_sat = u_r[COL_W-1:0];
    end
    kind_cur = kind_r[v_r[RW-1:0]];
    merged   = ram_rd_data;
    if (kind_cur == KIND_NONE) begin
      merged.left_u  = u_sat;
      merged.right_u = u_sat;
      merged.left_w  = w_r;
      merged.right_w = w_r;
    end else begin
      if (u_sat < ram_rd_data.left_u) begin
        merged.left_u = u_sat;
        merged.left_w = w_r;
      end
      if (u_sat > ram_rd_data.right_u) begin
        merged.right_u = u_sat;
        merged.right_w = w_r;
      end
    end
    kind_emit = kind_r[RW'(erow_r)];
  end

  assign load_ok = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (dcnt_r == DIV_LAST) begin
          state_nxt = ST_WALK_RD;
        end
      end
      ST_WALK_RD: begin
        state_nxt = ST_WALK_WR;
      end
      ST_WALK_WR: begin
        if (cnt_r == (COL_W+1)'(1)) begin
          state_nxt = in_r.closes_shape ? ST_EMIT_RD : ST_IDLE;
        end else begin
          state_nxt = ST_WALK_RD;
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (load_ok) begin
          state_nxt = (erow_r == LAST_ROW) ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath and port outputs per state.
  always_comb begin
    in_nxt        = in_r;
    kind_nxt      = kind_r;
    maj_nxt       = maj_r;
    min_nxt       = min_r;
    umaj_nxt      = umaj_r;
    udec_nxt      = udec_r;
    vdec_nxt      = vdec_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    w_nxt         = w_r;
    inrow_nxt     = inrow_r;
    neg_nxt       = neg_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    step_nxt      = step_r;
    erow_nxt      = erow_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    ram_we        = 1'b0;
    ram_wr_addr   = v_r[RW-1:0];
    ram_wr_data   = merged;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = v_pt[RW-1:0];
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        in_nxt   = in_item;
      end
      ST_SETUP: begin
        umaj_nxt = (adu > adv);
        maj_nxt  = (adu > adv) ? adu : adv;
        min_nxt  = (adu > adv) ? adv : adu;
        udec_nxt = du[COL_W] || (du == '0);
        vdec_nxt = dv[COL_W] || (dv == '0);
        cnt_nxt  = {1'b0, ((adu > adv) ? adu : adv)} + (COL_W+1)'(1);
        acc_nxt  = '0;
        u_nxt    = {{(WALK_W-COL_W){in_r.src_u[COL_W-1]}}, in_r.src_u};
        v_nxt    = {{(WALK_W-COL_W){in_r.src_v[COL_W-1]}}, in_r.src_v};
        w_nxt    = in_r.src_w;
        neg_nxt  = wdiff[DEPTH_W];
        dvd_nxt  = wdiff[DEPTH_W] ? wdiff_neg[DEPTH_W-1:0] : wdiff[DEPTH_W-1:0];
        rem_nxt  = '0;
        dcnt_nxt = '0;
      end
      ST_DIV: begin
        rem_nxt  = q_bit ? rem_sub[COL_W-1:0] : rem_sh[COL_W-1:0];
        dvd_nxt  = {dvd_r[DEPTH_W-2:0], q_bit};
        dcnt_nxt = dcnt_r + 5'd1;
      end
      ST_WALK_RD: begin
        // dvd_r holds the quotient magnitude from here on.
        step_nxt  = neg_r ? (-dvd_r) : dvd_r;
        acc_nxt   = acc_pt;
        u_nxt     = u_pt;
        v_nxt     = v_pt;
        inrow_nxt = v_pt_in;
        ram_rd_en = v_pt_in;
      end
      ST_WALK_WR: begin
        ram_we  = inrow_r;
        if (inrow_r) begin
          kind_nxt[v_r[RW-1:0]] = (kind_cur == KIND_NONE) ? KIND_POINT : KIND_SPAN;
        end
        acc_nxt = acc_r + ACC_W'(min_r);
        if (umaj_r) begin
          u_nxt = u_r + (udec_r ? STEP_DEC : STEP_INC);
        end else begin
          v_nxt = v_r + (vdec_r ? STEP_DEC : STEP_INC);
        end
        w_nxt    = w_r + step_r;
        cnt_nxt  = cnt_r - (COL_W+1)'(1);
        erow_nxt = '0;
      end
      ST_EMIT_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = RW'(erow_r);
      end
      ST_EMIT_LD: begin
        if (load_ok) begin
          out_valid_nxt          = 1'b1;
          out_item_nxt.row_index = erow_r;
          out_item_nxt.span_kind = kind_emit;
          out_item_nxt.last_row  = (erow_r == LAST_ROW);
          if (kind_emit == KIND_NONE) begin
            out_item_nxt.left_u  = '0;
            out_item_nxt.left_w  = '0;
            out_item_nxt.right_u = '0;
            out_item_nxt.right_w = '0;
          end else begin
            out_item_nxt.left_u  = ram_rd_data.left_u;
            out_item_nxt.left_w  = ram_rd_data.left_w;
            out_item_nxt.right_u = ram_rd_data.right_u;
            out_item_nxt.right_w = ram_rd_data.right_w;
          end
          erow_nxt = erow_r + ROWI_W'(1);
          if (erow_r == LAST_ROW) begin
            kind_nxt = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kind_r      <= '0;
      out_valid_r <= 1'b0;
      erow_r      <= '0;
      cnt_r       <= '0;
      dcnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
      erow_r      <= erow_nxt;
      cnt_r       <= cnt_nxt;
      dcnt_r      <= dcnt_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    maj_r      <= maj_nxt;
    min_r      <= min_nxt;
    umaj_r     <= umaj_nxt;
    udec_r     <= udec_nxt;
    vdec_r     <= vdec_nxt;
    acc_r      <= acc_nxt;
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    w_r        <= w_nxt;
    inrow_r    <= inrow_nxt;
    neg_r      <= neg_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTH
  // A table write always leaves its row marked as touched.
  a_write_marks_row: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (kind_r[$past(ram_wr_addr)] != KIND_NONE))
    else $error("row written without being marked touched");

  // Reporting the last row clears the row kinds of the whole table.
  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_LD && load_ok && erow_r == LAST_ROW) |=> (kind_r == '0))
    else $error("span table not cleared after the closing edge");

  // An untouched row reports zero columns and depths.
  a_untouched_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.span_kind == KIND_NONE) |->
      (out_item_r.left_u == '0 && out_item_r.left_w == '0 &&
       out_item_r.right_u == '0 && out_item_r.right_w == '0))
    else $error("untouched row carries data");

  // The point counter never runs out during a walk.
  a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK_RD || state_r == ST_WALK_WR) |-> (cnt_r != '0))
    else $error("walk point counter underflow");
`endif

endmodule
